// ===== hdl/upd_pkg.sv =====
// Package for the URL percent decoder: channel payload types, the result group
// type passed between the front and back parts, and the hex digit helpers.
// It depends on nothing.
`default_nettype none

package upd_pkg;

   localparam logic [7:0] PCT_CHAR        = 8'h25;
   localparam logic [7:0] HEX_LETTER_BASE = 8'd10;
   localparam int         GROUP_MAX       = 3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // Results caused by one input item, in order from index zero.
   typedef struct packed {
      logic [GROUP_MAX-1:0][7:0] bytes;
      logic [1:0]                count;
      logic                      last;
   } group_type;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_PCT   = 2'd1,
      PEND_DIGIT = 2'd2
   } pend_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
         t = c - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
         t = c - 8'h41 + HEX_LETTER_BASE;
      end else if (c inside {[8'h61:8'h66]}) begin
         t = c - 8'h61 + HEX_LETTER_BASE;
      end
      return t[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/upd_front.sv =====
// Front part of the URL percent decoder: accepts input bytes, tracks a partial
// escape and turns each byte into a group of zero to three results.
// Depends on upd_pkg.
`default_nettype none

module upd_front import upd_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  req_type    req_data,
   input  wire        accept,
   output logic       grp_push,
   output group_type  grp_data
);

   pend_type   state_ff;
   pend_type   state_in;
   logic [7:0] hold_ff;
   logic [7:0] hold_in;
   logic [1:0] n;
   logic       to_fresh;
   logic [7:0] b;

   assign b = req_data.in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PEND_NONE;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      hold_in  = hold_ff;
      grp_data = '0;
      n        = 2'd0;
      to_fresh = 1'b0;
      case (state_ff)
         PEND_PCT: begin
            if (is_hex(b)) begin
               state_in = PEND_DIGIT;
               hold_in  = b;
            end else begin
               grp_data.bytes[n] = PCT_CHAR;
               n = n + 2'd1;
               to_fresh = 1'b1;
            end
         end
         PEND_DIGIT: begin
            if (is_hex(b)) begin
               grp_data.bytes[n] = {hex_value(hold_ff), hex_value(b)};
               n = n + 2'd1;
               state_in = PEND_NONE;
            end else begin
               grp_data.bytes[n] = PCT_CHAR;
               n = n + 2'd1;
               grp_data.bytes[n] = hold_ff;
               n = n + 2'd1;
               to_fresh = 1'b1;
            end
         end
         default: begin
            to_fresh = 1'b1;
         end
      endcase
      if (to_fresh) begin
         if (b == PCT_CHAR) begin
            state_in = PEND_PCT;
         end else begin
            grp_data.bytes[n] = b;
            n = n + 2'd1;
            state_in = PEND_NONE;
         end
      end
      if (req_data.in_last) begin
         if (state_in != PEND_NONE) begin
            grp_data.bytes[n] = PCT_CHAR;
            n = n + 2'd1;
         end
         if (state_in == PEND_DIGIT) begin
            grp_data.bytes[n] = hold_in;
            n = n + 2'd1;
         end
         state_in = PEND_NONE;
      end
      grp_data.count = n;
      grp_data.last  = req_data.in_last;
      grp_push       = accept && (n != 2'd0);
   end

   // A final byte always produces a group and leaves no escape pending.
   a_last_pushes: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.in_last |-> grp_push)
      else $error("final byte produced no results");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.in_last |=> state_ff == PEND_NONE)
      else $error("escape still pending after final byte");

endmodule

`default_nettype wire

// ===== hdl/upd_queue.sv =====
// Two-entry queue of result groups between the front and back parts of the
// URL percent decoder. Depends on upd_pkg.
`default_nettype none

module upd_queue import upd_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        push,
   input  group_type  push_data,
   output logic       full,
   input  wire        deq,
   output logic       head_valid,
   output group_type  head_data
);

   group_type  mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_deq;

   assign do_deq     = deq && head_valid;
   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !do_deq) begin
         count_in = count_ff + 2'd1;
      end else if (!push && do_deq) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_deq) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("group pushed into a full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== hdl/upd_emit.sv =====
// Back part of the URL percent decoder: walks through the head group into the registered
// result port, one result per cycle while it is empty or popped. Depends on upd_pkg.
`default_nettype none

module upd_emit import upd_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        head_valid,
   input  group_type  head_data,
   output logic       deq,
   output logic       rsp_empty,
   input  wire        rsp_pop,
   output rsp_type    rsp_data
);

   logic       valid_ff;
   logic       valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       load;
   logic       at_end;

   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;
   assign load      = head_valid && (!valid_ff || rsp_pop);
   assign at_end    = (idx_ff == (head_data.count - 2'd1));

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      idx_in   = idx_ff;
      deq      = 1'b0;
      if (load) begin
         valid_in        = 1'b1;
         rsp_in.out_byte = head_data.bytes[idx_ff];
         rsp_in.out_last = head_data.last && at_end;
         if (at_end) begin
            deq    = 1'b1;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff < head_data.count)
      else $error("result index beyond head group");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == 2'd0)
      else $error("result index not reset between groups");

endmodule

`default_nettype wire

// ===== hdl/url_percent_decoder_core.sv =====
// Top level of the URL percent decoder: front classifier, group queue and
// result emitter. Depends on upd_pkg, upd_front, upd_queue and upd_emit.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_push / req_full   req_data  (req_type)
//   rsp_      out        rsp_pop / rsp_empty   rsp_data  (rsp_type)
//
// An input byte is taken each cycle while the two-entry group queue has room.
// A byte causes zero to three results, which the emitter delivers one per
// cycle while the receiver pops, so the sustained rate is one byte per cycle
// when each byte causes at most one result; otherwise the result rate limits it.
// A result is written into the group queue and then into the result register
// before it appears on rsp_data.
// Synchronous reset empties the queue and the result register and drops any
// partial escape.
`default_nettype none

module url_percent_decoder_core import upd_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  wire      req_push,
   output logic     req_full,
   input  req_type  req_data,
   output logic     rsp_empty,
   input  wire      rsp_pop,
   output rsp_type  rsp_data
);

   logic      accept;
   logic      grp_push;
   group_type grp_data;
   logic      head_valid;
   group_type head_data;
   logic      deq;

   assign accept = req_push && !req_full;

   upd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .accept   (accept),
      .grp_push (grp_push),
      .grp_data (grp_data)
   );

   upd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (grp_push),
      .push_data  (grp_data),
      .full       (req_full),
      .deq        (deq),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   upd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .deq        (deq),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== dv/url_percent_decoder_core_test.sv =====
// Self-checking testbench for url_percent_decoder_core: directed, random encoded
// path and random noise tests, with a built-in decoder predictor and an in-order checker.
// Depends on upd_pkg and the url_percent_decoder_core RTL.
`default_nettype none

module url_percent_decoder_core_test;
   import upd_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   pend_type   pend_state = PEND_NONE;
   logic [7:0] held_digit = 8'h00;
   rsp_type    expected_decoded[$];
   int         error_count = 0;
   int         items_sent = 0;
   int         burst_left = 0;
   int         idle_cycles = 0;
   int         stall_mode = 0;
   int         stall_phase = 0;

   url_percent_decoder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Returns the value of a hex digit, or -1 for any other byte.
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return int'(c) - int'("0");
      end else if (c >= "A" && c <= "F") begin
         return int'(c) - int'("A") + 10;
      end else if (c >= "a" && c <= "f") begin
         return int'(c) - int'("a") + 10;
      end
      return -1;
   endfunction

   function automatic void predict_decode(input logic [7:0] value, input logic mark_last);
      logic [7:0] outs[$];
      int         hi;
      int         lo;
      logic       take_fresh;
      rsp_type    r;
      take_fresh = 1'b0;
      case (pend_state)
         PEND_PCT: begin
            if (hex_nibble(value) >= 0) begin
               held_digit = value;
               pend_state = PEND_DIGIT;
            end else begin
               outs.push_back(PCT_CHAR);
               pend_state = PEND_NONE;
               take_fresh = 1'b1;
            end
         end
         PEND_DIGIT: begin
            if (hex_nibble(value) >= 0) begin
               hi = hex_nibble(held_digit);
               lo = hex_nibble(value);
               outs.push_back(8'(hi * 16 + lo));
               pend_state = PEND_NONE;
            end else begin
               outs.push_back(PCT_CHAR);
               outs.push_back(held_digit);
               pend_state = PEND_NONE;
               take_fresh = 1'b1;
            end
         end
         default: begin
            pend_state = PEND_NONE;
            take_fresh = 1'b1;
         end
      endcase
      if (take_fresh) begin
         if (value == PCT_CHAR) begin
            pend_state = PEND_PCT;
         end else begin
            outs.push_back(value);
         end
      end
      if (mark_last) begin
         if (pend_state != PEND_NONE) begin
            outs.push_back(PCT_CHAR);
         end
         if (pend_state == PEND_DIGIT) begin
            outs.push_back(held_digit);
         end
         pend_state = PEND_NONE;
         held_digit = 8'h00;
      end
      foreach (outs[i]) begin
         r.out_byte = outs[i];
         r.out_last = mark_last && (i == outs.size() - 1);
         expected_decoded.push_back(r);
      end
   endfunction

   function automatic logic [7:0] rand_hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return 8'("0" + v);
      end
      return ($urandom_range(0, 1) == 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
   endfunction

   function automatic logic [7:0] rand_plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(8'h20, 8'h7e));
      return (c == PCT_CHAR) ? 8'h2f : c;
   endfunction

   function automatic logic [7:0] rand_noise_byte();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
         return PCT_CHAR;
      end else if (pick == 1) begin
         return rand_hex_char();
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Drives one byte and holds it until the transfer completes. The sender
   // runs in bursts separated by idle gaps, though some bursts follow on without one.
   task automatic send_byte(input logic [7:0] value, input logic mark_last);
      int      gap;
      req_type item;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      item.in_byte = value;
      item.in_last = mark_last;
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      predict_decode(value, mark_last);
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic mark_last);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_byte(s[i], mark_last && (i == s.len() - 1));
      end
   endtask

   task automatic test_directed();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_text("%41%fA", 1'b0);
      send_text("%g%%7e", 1'b0);
      send_text("%4z", 1'b0);
      send_text("%", 1'b1);
      send_text("%c", 1'b1);
      send_text("x", 1'b1);
      send_text("%09", 1'b1);
   endtask

   // Well-formed paths with random content, mixed with some noise bytes.
   task automatic test_random_paths(input int stop_at);
      int   len;
      int   i;
      int   kind;
      logic at_end;
      while (items_sent < stop_at) begin
         len = $urandom_range(1, 10);
         for (i = 0; i < len; i++) begin
            kind = $urandom_range(0, 9);
            at_end = (i == len - 1);
            if (kind < 4) begin
               send_byte(PCT_CHAR, 1'b0);
               send_byte(rand_hex_char(), 1'b0);
               send_byte(rand_hex_char(), at_end);
            end else if (kind < 8) begin
               send_byte(rand_plain_char(), at_end);
            end else begin
               send_byte(rand_noise_byte(), at_end);
            end
         end
      end
   endtask

   task automatic test_random_noise(input int stop_at);
      while (items_sent < stop_at) begin
         send_byte(rand_noise_byte(), $urandom_range(0, 7) == 0);
      end
   endtask

   // Checks every result transfer and drives the receiver stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_decoded.size() == 0) begin
               $error("unexpected result: out_byte=%h out_last=%b",
                      rsp_data.out_byte, rsp_data.out_last);
               error_count++;
            end else begin
               if (rsp_data.out_byte !== expected_decoded[0].out_byte) begin
                  $error("out_byte: expected %h, actual %h",
                         expected_decoded[0].out_byte, rsp_data.out_byte);
                  error_count++;
               end
               if (rsp_data.out_last !== expected_decoded[0].out_last) begin
                  $error("out_last: expected %b, actual %b",
                         expected_decoded[0].out_last, rsp_data.out_last);
                  error_count++;
               end
               void'(expected_decoded.pop_front());
            end
         end
         if (stall_phase == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_phase = $urandom_range(20, 120);
         end
         stall_phase--;
         case (stall_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= ($urandom_range(0, 3) != 0);
            2: rsp_pop <= ($urandom_range(0, 3) == 0);
            default: rsp_pop <= stall_phase[0];
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles < IDLE_LIMIT) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         $display("** url_percent_decoder_core: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_paths(300);
      test_random_noise(450);
      req_push <= 1'b0;
      while (expected_decoded.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_decoded.size() == 0) begin
         $display("** url_percent_decoder_core: PASSED **");
      end else begin
         $display("** url_percent_decoder_core: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
